/* src/assert_macros.svh */
// Assertion macros used by the top level RTL file of the warp mapper.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/pcwm_pkg.sv */
// Types, codes and helper functions for the pixel coordinate warp mapper.
// No dependencies.
package pcwm_pkg;

    localparam int MW = 42;
    localparam logic [40:0] CLAMP_MAG = 41'h100_0000_0000;

    localparam logic [1:0] MODE_AFFINE = 2'd0;
    localparam logic [1:0] MODE_PROJ   = 2'd1;
    localparam logic [1:0] MODE_RADIAL = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_LIN_ROW0 = 3'd1;
    localparam logic [2:0] REG_LIN_ROW1 = 3'd2;
    localparam logic [2:0] REG_OFFSETS  = 3'd3;
    localparam logic [2:0] REG_PERSP_XY = 3'd4;
    localparam logic [2:0] REG_PERSP_C  = 3'd5;
    localparam logic [2:0] REG_RADIAL_A = 3'd6;

    localparam logic [31:0] PERSP_C_RST = 32'h0100_0000;

    localparam int DIV_QB = 49;
    localparam int DIV_FB = 17;
    localparam int MUL_LAT = 3;

    typedef struct packed {
        logic        flag;
        logic [31:0] val;
    } t_sat;

    function automatic logic signed [MW-1:0] sgn_clamp(input logic [63:0] mag,
                                                       input logic neg);
        logic [63:0] m;
        logic signed [MW-1:0] s;
        m = (mag > 64'(CLAMP_MAG)) ? 64'(CLAMP_MAG) : mag;
        s = signed'(MW'(m));
        return neg ? -s : s;
    endfunction

    function automatic t_sat sat32(input logic signed [MW:0] v);
        t_sat r;
        r.flag = 1'b0;
        r.val  = v[31:0];
        if (v > (MW+1)'(signed'(32'h7FFF_FFFF))) begin
            r.flag = 1'b1;
            r.val  = 32'h7FFF_FFFF;
        end else if (v < (MW+1)'(signed'(32'h8000_0000))) begin
            r.flag = 1'b1;
            r.val  = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

/* src/pixel_coordinate_warp_mapper.sv */
// Top level of the pixel coordinate warp mapper: config registers and the pipeline.
// Depends on pcwm_pkg, pcwm_mul, pcwm_div, pcwm_dly and assert_macros.svh.
//
//  channel  | handshake             | beat
//  ---------+-----------------------+------------------------------------------
//  input    | i_valid / o_stall     | i_pixel_x, i_pixel_y
//  output   | o_valid / i_stall     | o_mapped_x/y, o_displacement_x/y, o_map_status
//  config   | psel penable pwrite   | paddr, pwdata, prdata (64 bit, reg i at 8*i)
//
// One beat per cycle in while the output beat is not stalled; the divider pipeline
// (one quotient bit per stage) sets the depth from input to output.
// The whole pipeline advances together and freezes while the output beat is stalled.
// Reset clears the valid bits and loads the register reset values.
`include "assert_macros.svh"

module pixel_coordinate_warp_mapper #(
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_BITS-1:0]  i_pixel_x,
    input  logic [COORD_BITS-1:0]  i_pixel_y,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [31:0]            o_mapped_x,
    output logic [31:0]            o_mapped_y,
    output logic [31:0]            o_displacement_x,
    output logic [31:0]            o_displacement_y,
    output logic [1:0]             o_map_status,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);
    localparam int CB  = COORD_BITS;
    localparam int MW  = pcwm_pkg::MW;
    localparam int PW  = 33 + CB;
    localparam int NW  = ((PW > 44) ? PW : 44) + 2;
    localparam int DW  = (((CB + 13) > 32) ? (CB + 13) : 32) + 1;
    localparam int SQW = 2 * DW;
    localparam int R2W = SQW + 1;
    localparam int ARW = 64 + R2W;
    localparam int TW  = ARW + DW;
    localparam int SW  = ((TW > (CB + 84)) ? TW : (CB + 84)) + 2;
    localparam int QB  = pcwm_pkg::DIV_QB;
    localparam int ML  = pcwm_pkg::MUL_LAT;
    localparam int LAT = 4 + QB + 2;
    localparam int K_PROJ = 5 + QB;          // stage of the projective result
    localparam int K_AR2  = 4 + 2 * ML;      // stage of a*r^2
    localparam int K_RAD  = K_AR2 + ML + 3;  // stage of the radial result

    // ---------------- configuration ----------------
    logic [1:0]  r_mode;
    logic [63:0] r_lin0, r_lin1, r_off, r_pxy, r_rad;
    logic [31:0] r_pc;
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pcwm_pkg::MODE_AFFINE;
            r_lin0 <= '0;
            r_lin1 <= '0;
            r_off  <= '0;
            r_pxy  <= '0;
            r_pc   <= pcwm_pkg::PERSP_C_RST;
            r_rad  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pcwm_pkg::REG_MODE:     r_mode <= pwdata[1:0];
                pcwm_pkg::REG_LIN_ROW0: r_lin0 <= pwdata;
                pcwm_pkg::REG_LIN_ROW1: r_lin1 <= pwdata;
                pcwm_pkg::REG_OFFSETS:  r_off  <= pwdata;
                pcwm_pkg::REG_PERSP_XY: r_pxy  <= pwdata;
                pcwm_pkg::REG_PERSP_C:  r_pc   <= pwdata[31:0];
                pcwm_pkg::REG_RADIAL_A: r_rad  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pcwm_pkg::REG_MODE:     prdata = 64'(r_mode);
            pcwm_pkg::REG_LIN_ROW0: prdata = r_lin0;
            pcwm_pkg::REG_LIN_ROW1: prdata = r_lin1;
            pcwm_pkg::REG_OFFSETS:  prdata = r_off;
            pcwm_pkg::REG_PERSP_XY: prdata = r_pxy;
            pcwm_pkg::REG_PERSP_C:  prdata = 64'(r_pc);
            pcwm_pkg::REG_RADIAL_A: prdata = r_rad;
            default:                prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic           en;
    logic [LAT-1:0] r_vld;

    assign o_stall = r_vld[LAT-1] & i_stall;
    assign en      = ~o_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage 1: input beat
    logic [CB-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
    end

    // ---------------- affine / projective ----------------
    logic signed [31:0] h0, h1, h2, h3, h4, h5, h6, h7, h8;
    assign h0 = signed'(r_lin0[63:32]);
    assign h1 = signed'(r_lin0[31:0]);
    assign h3 = signed'(r_lin1[63:32]);
    assign h4 = signed'(r_lin1[31:0]);
    assign h2 = signed'(r_off[63:32]);
    assign h5 = signed'(r_off[31:0]);
    assign h6 = signed'(r_pxy[63:32]);
    assign h7 = signed'(r_pxy[31:0]);
    assign h8 = signed'(r_pc);

    logic signed [CB:0]   sx1, sy1;
    logic signed [PW-1:0] r_pr [6];
    logic signed [NW-1:0] r_nx, r_ny, r_z;

    assign sx1 = signed'({1'b0, r_px});
    assign sy1 = signed'({1'b0, r_py});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pr[0] <= PW'(h0) * PW'(sx1);
            r_pr[1] <= PW'(h1) * PW'(sy1);
            r_pr[2] <= PW'(h3) * PW'(sx1);
            r_pr[3] <= PW'(h4) * PW'(sy1);
            r_pr[4] <= PW'(h6) * PW'(sx1);
            r_pr[5] <= PW'(h7) * PW'(sy1);
            r_nx <= NW'(r_pr[0]) + NW'(r_pr[1]) + (NW'(h2) <<< 12);
            r_ny <= NW'(r_pr[2]) + NW'(r_pr[3]) + (NW'(h5) <<< 12);
            r_z  <= NW'(r_pr[4]) + NW'(r_pr[5]) + (NW'(h8) <<< 8);
        end
    end

    // stage 4: affine rounding and divider operands
    logic [NW-1:0] unx, uny, udz;
    logic [NW:0]   rax, ray;
    logic signed [MW-1:0] r_max, r_may;
    logic [NW-1:0] r_unx, r_uny, r_udz;
    logic [2:0]    r_pflags;   // {zero, ovf y, ovf x}
    logic          r_negx, r_negy;

    assign unx = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
    assign uny = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
    assign udz = r_z[NW-1]  ? NW'(-r_z)  : NW'(r_z);
    assign rax = ((NW+1)'(unx) + (NW+1)'(17'h8000)) >> 16;
    assign ray = ((NW+1)'(uny) + (NW+1)'(17'h8000)) >> 16;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_max  <= pcwm_pkg::sgn_clamp(64'(rax), r_nx[NW-1]);
            r_may  <= pcwm_pkg::sgn_clamp(64'(ray), r_ny[NW-1]);
            r_unx  <= unx;
            r_uny  <= uny;
            r_udz  <= udz;
            r_negx <= r_nx[NW-1] ^ r_z[NW-1];
            r_negy <= r_ny[NW-1] ^ r_z[NW-1];
            r_pflags <= {(r_z == '0),
                         ((NW+32)'(uny) >= {udz, 32'h0}),
                         ((NW+32)'(unx) >= {udz, 32'h0})};
        end
    end

    logic [QB-1:0] qx, qy;
    pcwm_div #(.UW(NW), .QB(QB), .FB(pcwm_pkg::DIV_FB)) u_divx (
        .i_clk(i_clk), .i_en(en), .i_num(r_unx), .i_den(r_udz), .o_quo(qx)
    );
    pcwm_div #(.UW(NW), .QB(QB), .FB(pcwm_pkg::DIV_FB)) u_divy (
        .i_clk(i_clk), .i_en(en), .i_num(r_uny), .i_den(r_udz), .o_quo(qy)
    );

    logic [4:0] pside_d;
    pcwm_dly #(.W(5), .N(QB)) u_dly_pside (
        .i_clk(i_clk), .i_en(en),
        .i_d({r_pflags, r_negy, r_negx}), .o_d(pside_d)
    );

    logic [QB:0] hqx, hqy;
    logic signed [MW-1:0] r_mpx, r_mpy;
    logic        r_pz;
    assign hqx = ((QB+1)'(qx) + (QB+1)'(1)) >> 1;
    assign hqy = ((QB+1)'(qy) + (QB+1)'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mpx <= pcwm_pkg::sgn_clamp(pside_d[2] ? 64'(pcwm_pkg::CLAMP_MAG) : 64'(hqx),
                                         pside_d[0]);
            r_mpy <= pcwm_pkg::sgn_clamp(pside_d[3] ? 64'(pcwm_pkg::CLAMP_MAG) : 64'(hqy),
                                         pside_d[1]);
            r_pz  <= pside_d[4];
        end
    end

    logic [2*MW-1:0] maff_d;
    pcwm_dly #(.W(2*MW), .N(K_PROJ - 4)) u_dly_aff (
        .i_clk(i_clk), .i_en(en), .i_d({r_may, r_max}), .o_d(maff_d)
    );

    // ---------------- radial ----------------
    logic signed [DW-1:0] r_dx, r_dy;
    logic [DW-1:0] r_adx, r_ady;
    logic          r_dnx, r_dny, r_dz;
    logic          aneg;
    logic [63:0]   am;

    assign aneg = r_rad[63];
    assign am   = aneg ? (64'h0 - r_rad) : r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx  <= signed'(DW'({r_px, 12'h0})) - DW'(h2);
            r_dy  <= signed'(DW'({r_py, 12'h0})) - DW'(h5);
            r_adx <= r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
            r_ady <= r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
            r_dnx <= r_dx[DW-1];
            r_dny <= r_dy[DW-1];
            r_dz  <= (r_dx == '0) && (r_dy == '0);
        end
    end

    logic [SQW-1:0] s0, s1;
    logic [R2W-1:0] r_r2;
    pcwm_mul #(.AW(DW), .BW(DW)) u_sqx (
        .i_clk(i_clk), .i_en(en), .i_a(r_adx), .i_b(r_adx), .o_p(s0)
    );
    pcwm_mul #(.AW(DW), .BW(DW)) u_sqy (
        .i_clk(i_clk), .i_en(en), .i_a(r_ady), .i_b(r_ady), .o_p(s1)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2 <= R2W'(s0) + R2W'(s1);
        end
    end

    logic [ARW-1:0] ar2;
    pcwm_mul #(.AW(64), .BW(R2W)) u_ar2 (
        .i_clk(i_clk), .i_en(en), .i_a(am), .i_b(r_r2), .o_p(ar2)
    );

    logic [2*DW-1:0] ad_d;
    pcwm_dly #(.W(2*DW), .N(K_AR2 - 3)) u_dly_ad (
        .i_clk(i_clk), .i_en(en), .i_d({r_ady, r_adx}), .o_d(ad_d)
    );

    logic [TW-1:0] tx, ty;
    pcwm_mul #(.AW(ARW), .BW(DW)) u_tx (
        .i_clk(i_clk), .i_en(en), .i_a(ar2), .i_b(ad_d[DW-1:0]), .o_p(tx)
    );
    pcwm_mul #(.AW(ARW), .BW(DW)) u_ty (
        .i_clk(i_clk), .i_en(en), .i_a(ar2), .i_b(ad_d[2*DW-1:DW]), .o_p(ty)
    );

    logic [1:0] dn_d;
    pcwm_dly #(.W(2), .N(K_AR2 + ML - 3)) u_dly_dn (
        .i_clk(i_clk), .i_en(en), .i_d({r_dny, r_dnx}), .o_d(dn_d)
    );

    logic [2*CB-1:0] pr_d;
    pcwm_dly #(.W(2*CB), .N(K_AR2 + ML - 1)) u_dly_pr (
        .i_clk(i_clk), .i_en(en), .i_d({r_py, r_px}), .o_d(pr_d)
    );

    logic dz_d;
    pcwm_dly #(.W(1), .N(K_AR2 + ML - 1)) u_dly_dz (
        .i_clk(i_clk), .i_en(en), .i_d(r_dz), .o_d(dz_d)
    );

    logic [SW-1:0] bx, by;
    logic [SW-1:0] r_sx, r_sy, r_mgx, r_mgy;
    logic          r_sgx, r_sgy;
    logic signed [MW-1:0] r_mrx, r_mry;
    logic [40:0]   rrx, rry;

    assign bx = SW'(pr_d[CB-1:0]) << 84;
    assign by = SW'(pr_d[2*CB-1:CB]) << 84;
    assign rrx = {1'b0, r_mgx[115:76]} + 41'(r_mgx[75]);
    assign rry = {1'b0, r_mgy[115:76]} + 41'(r_mgy[75]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx  <= (aneg ^ dn_d[0]) ? (bx - SW'(tx)) : (bx + SW'(tx));
            r_sy  <= (aneg ^ dn_d[1]) ? (by - SW'(ty)) : (by + SW'(ty));
            r_sgx <= r_sx[SW-1];
            r_sgy <= r_sy[SW-1];
            r_mgx <= r_sx[SW-1] ? (SW'(0) - r_sx) : r_sx;
            r_mgy <= r_sy[SW-1] ? (SW'(0) - r_sy) : r_sy;
            if (dz_d) begin
                r_mrx <= '0;
                r_mry <= '0;
            end else begin
                r_mrx <= pcwm_pkg::sgn_clamp((|r_mgx[SW-1:116]) ?
                             64'(pcwm_pkg::CLAMP_MAG) : 64'(rrx), r_sgx);
                r_mry <= pcwm_pkg::sgn_clamp((|r_mgy[SW-1:116]) ?
                             64'(pcwm_pkg::CLAMP_MAG) : 64'(rry), r_sgy);
            end
        end
    end

    logic [2*MW-1:0] mrad_d;
    pcwm_dly #(.W(2*MW), .N(K_PROJ - K_RAD)) u_dly_rad (
        .i_clk(i_clk), .i_en(en), .i_d({r_mry, r_mrx}), .o_d(mrad_d)
    );

    logic [2*CB-1:0] pout_d;
    pcwm_dly #(.W(2*CB), .N(K_PROJ - 1)) u_dly_pout (
        .i_clk(i_clk), .i_en(en), .i_d({r_py, r_px}), .o_d(pout_d)
    );

    // ---------------- output stage ----------------
    logic signed [MW-1:0] msx, msy;
    logic signed [MW:0]   ddx, ddy;
    pcwm_pkg::t_sat       smx, smy, sdx, sdy;
    logic                 zden;

    always_comb begin
        zden = 1'b0;
        case (r_mode)
            pcwm_pkg::MODE_PROJ: begin
                msx  = r_mpx;
                msy  = r_mpy;
                zden = r_pz;
            end
            pcwm_pkg::MODE_RADIAL: begin
                msx = signed'(mrad_d[MW-1:0]);
                msy = signed'(mrad_d[2*MW-1:MW]);
            end
            default: begin
                msx = signed'(maff_d[MW-1:0]);
                msy = signed'(maff_d[2*MW-1:MW]);
            end
        endcase
        ddx = (MW+1)'(msx) - signed'((MW+1)'({pout_d[CB-1:0], 8'h0}));
        ddy = (MW+1)'(msy) - signed'((MW+1)'({pout_d[2*CB-1:CB], 8'h0}));
        smx = pcwm_pkg::sat32((MW+1)'(msx));
        smy = pcwm_pkg::sat32((MW+1)'(msy));
        sdx = pcwm_pkg::sat32(ddx);
        sdy = pcwm_pkg::sat32(ddy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (zden) begin
                o_mapped_x       <= '0;
                o_mapped_y       <= '0;
                o_displacement_x <= '0;
                o_displacement_y <= '0;
                o_map_status     <= pcwm_pkg::ST_ZDEN;
            end else begin
                o_mapped_x       <= smx.val;
                o_mapped_y       <= smy.val;
                o_displacement_x <= sdx.val;
                o_displacement_y <= sdy.val;
                o_map_status     <= (smx.flag | smy.flag | sdx.flag | sdy.flag) ?
                                    pcwm_pkg::ST_SAT : pcwm_pkg::ST_OK;
            end
        end
    end

    // ---------------- checks ----------------
    `ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_valid, "output valid after reset")
    `ASSERT_CLK(a_zden_zero, o_valid && (o_map_status == pcwm_pkg::ST_ZDEN) |-> (o_mapped_x == 0) && (o_mapped_y == 0) && (o_displacement_x == 0) && (o_displacement_y == 0), "zero denominator with nonzero result")
    `ASSERT_CLK(a_zden_mode, o_valid && (o_map_status == pcwm_pkg::ST_ZDEN) |-> (r_mode == pcwm_pkg::MODE_PROJ), "zero denominator outside projective mode")

endmodule

/* src/pcwm_dly.sv */
// Enabled delay line for the warp mapper pipeline.
// No dependencies.
module pcwm_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_d = r_sh[N-1];
endmodule

/* src/pcwm_mul.sv */
// Pipelined unsigned multiplier built from 32x32 limb products, three stages.
// No dependencies.
module pcwm_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int XW = NA * 32;
    localparam int YW = NB * 32;
    localparam int SW = XW + YW;
    localparam int PW = AW + BW;

    logic [XW-1:0] a_x;
    logic [YW-1:0] b_x;
    logic [63:0]   r_pp  [NA][NB];
    logic [SW-1:0] r_row [NA];
    logic [SW-1:0] n_row [NA];
    logic [SW-1:0] n_sum;
    logic [PW-1:0] r_p;

    assign a_x = XW'(i_a);
    assign b_x = YW'(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (SW'(r_pp[i][j]) << (32 * j));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] << (32 * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= 64'(a_x[32*i +: 32]) * 64'(b_x[32*j +: 32]);
                end
                r_row[i] <= n_row[i];
            end
            r_p <= n_sum[PW-1:0];
        end
    end

    assign o_p = r_p;
endmodule

/* src/pcwm_div.sv */
// Pipelined restoring divider, one quotient bit per stage:
// quotient = floor(num * 2^FB / den), valid when it fits in QB bits. No dependencies.
module pcwm_div #(
    parameter int UW = 48,
    parameter int QB = 49,
    parameter int FB = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [UW-1:0] i_num,
    input  logic [UW-1:0] i_den,
    output logic [QB-1:0] o_quo
);
    localparam int RW = UW + FB;
    localparam int CW = UW + QB;

    logic [RW-1:0] r_rem [QB];
    logic [UW-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [RW-1:0] n_rem [QB];
    logic [QB-1:0] n_quo [QB];
    logic [UW-1:0] n_den [QB];

    always_comb begin
        logic [RW-1:0] rin;
        logic [QB-1:0] qin;
        logic [CW-1:0] dsh;
        logic          ge;
        for (int i = 0; i < QB; i++) begin
            if (i == 0) begin
                rin      = RW'(i_num) << FB;
                qin      = '0;
                n_den[i] = i_den;
            end else begin
                rin      = r_rem[i-1];
                qin      = r_quo[i-1];
                n_den[i] = r_den[i-1];
            end
            dsh      = CW'(n_den[i]) << (QB - 1 - i);
            ge       = (CW'(rin) >= dsh);
            n_rem[i] = ge ? RW'(CW'(rin) - dsh) : rin;
            n_quo[i] = qin | (QB'(ge) << (QB - 1 - i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < QB; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                r_den[i] <= n_den[i];
            end
        end
    end

    assign o_quo = r_quo[QB-1];
endmodule
